[rtl/mstc_pkg.sv]
// mstc_pkg: shared constants and controller/datapath interface types
// for the minimum spanning tree cost unit; no dependencies
`timescale 1ns / 1ps

package mstc_pkg;

  localparam int MAX_VERTICES = 256;
  localparam int MAX_EDGES    = 1024;
  localparam int WEIGHT_BITS  = 16;

  localparam int END_BITS    = 8;
  localparam int INW_BITS    = 16;
  localparam int VCNT_BITS   = 9;
  localparam int COST_BITS   = 24;
  localparam int TAKEN_BITS  = 8;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;

  localparam logic [VCNT_BITS-1:0] VCNT_RESET = 9'd1;
  localparam logic [COST_BITS-1:0] COST_MAX   = 24'hFFFFFF;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;      // input item accepted
    logic start;     // begin a compute
    logic init_wr;   // write one singleton entry of the parent store
    logic scan_clr;  // begin a pass over the edge store
    logic scan_rd;   // issue one edge store read
    logic mark;      // best edge becomes the last visited key
    logic sel_a;     // walker starts at endpoint a
    logic sel_b;     // walker starts at endpoint b
    logic hop;       // walker moves to its parent
    logic save_a;    // walker position is the root of a
    logic link;      // link root of a under root of b
    logic publish;   // load the result register
  } mstc_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic init_last;
    logic scan_done;
    logic rd_pend;
    logic found;
    logic out_range;
    logic is_root;
    logic same_set;
    logic more;
    logic out_busy;
  } mstc_sts_t;

endpackage

[rtl/minimum_spanning_tree_cost_unit.sv]
// minimum_spanning_tree_cost_unit: top level, edge stream in, tree cost out
// depends on mstc_pkg, mstc_ctrl, mstc_dp, mstc_ram
//
// channel   dir  handshake                  payload
// s_axis    in   s_axis_tvalid/tready       tdata end_a,end_b,edge_weight; tuser; tlast
// m_axis    out  m_axis_tvalid/tready       tdata connected,total_cost,edges_taken,overflow
// cfg       in   cfg_valid/cfg_ready        cfg_data vertex_count
//
// edges load one a cycle; after the last item the parent store is swept
// over all MAX_VERTICES entries, then each edge visit costs a pass over the
// edge store with its pick plus a parent read and a root check per node on
// each of the two root walks.
// rst is synchronous; the parent store needs no clearing pass after reset.
// input is held off from the last item until the result is registered;
// a waiting result holds the next compute in its final state until taken.
`timescale 1ns / 1ps

module minimum_spanning_tree_cost_unit #(
  parameter int MAX_VERTICES = mstc_pkg::MAX_VERTICES,
  parameter int MAX_EDGES    = mstc_pkg::MAX_EDGES,
  parameter int WEIGHT_BITS  = mstc_pkg::WEIGHT_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [mstc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // end_a, end_b, edge_weight
  input  logic                                 s_axis_tuser,  // edge_present
  input  logic                                 s_axis_tlast,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [mstc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // connected, total_cost,
                                                              // edges_taken, overflow, pad
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mstc_pkg::VCNT_BITS-1:0]       cfg_data
);

  mstc_pkg::mstc_cmd_t cmd;
  mstc_pkg::mstc_sts_t sts;

  logic                              connected, overflow;
  logic [mstc_pkg::COST_BITS-1:0]    total_cost;
  logic [mstc_pkg::TAKEN_BITS-1:0]   edges_taken;

  assign cfg_ready = 1'b1;

  mstc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_last  (s_axis_tlast),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mstc_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .in_present    (s_axis_tuser),
    .in_a          (s_axis_tdata[7:0]),
    .in_b          (s_axis_tdata[15:8]),
    .in_w          (s_axis_tdata[31:16]),
    .cfg_we        (cfg_valid),
    .cfg_value     (cfg_data),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .out_connected (connected),
    .out_cost      (total_cost),
    .out_taken     (edges_taken),
    .out_overflow  (overflow)
  );

  // result packing, lowest field first
  assign m_axis_tdata = {6'b0, overflow, edges_taken, total_cost, connected};

endmodule

[rtl/mstc_ram.sv]
// mstc_ram: generic simple dual port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module mstc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/mstc_ctrl.sv]
// mstc_ctrl: sequencer for load, parent init, scan passes and root walks
// depends on mstc_pkg
`timescale 1ns / 1ps

module mstc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_last,
  output logic               in_ready,
  input  mstc_pkg::mstc_sts_t sts,
  output mstc_pkg::mstc_cmd_t cmd
);

  typedef enum logic [3:0] {
    IDLE, INIT, SCAN_BEGIN, SCAN, PICK, FA_RD, FA_CHK, FB_RD, FB_CHK, DONE
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) begin
            cmd.start  = 1'b1;
            state_next = INIT;
          end
        end
      end
      INIT: begin
        cmd.init_wr = 1'b1;
        if (sts.init_last) state_next = SCAN_BEGIN;
      end
      SCAN_BEGIN: begin
        if (!sts.more) begin
          state_next = DONE;
        end else begin
          cmd.scan_clr = 1'b1;
          state_next   = SCAN;
        end
      end
      SCAN: begin
        if (!sts.scan_done) cmd.scan_rd = 1'b1;
        else if (!sts.rd_pend) state_next = PICK;
      end
      PICK: begin
        if (!sts.found) begin
          state_next = DONE;
        end else begin
          cmd.mark = 1'b1;
          if (sts.out_range) begin
            state_next = SCAN_BEGIN;
          end else begin
            cmd.sel_a  = 1'b1;
            state_next = FA_RD;
          end
        end
      end
      FA_RD: state_next = FA_CHK;
      FA_CHK: begin
        if (sts.is_root) begin
          cmd.save_a = 1'b1;
          cmd.sel_b  = 1'b1;
          state_next = FB_RD;
        end else begin
          cmd.hop    = 1'b1;
          state_next = FA_RD;
        end
      end
      FB_RD: state_next = FB_CHK;
      FB_CHK: begin
        if (sts.is_root) begin
          cmd.link   = !sts.same_set;
          state_next = SCAN_BEGIN;
        end else begin
          cmd.hop    = 1'b1;
          state_next = FB_RD;
        end
      end
      DONE: begin
        if (!sts.out_busy) begin
          cmd.publish = 1'b1;
          state_next  = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[rtl/mstc_dp.sv]
// mstc_dp: edge store, parent store, scan compare, counters, result register
// depends on mstc_pkg and mstc_ram
`timescale 1ns / 1ps

module mstc_dp #(
  parameter int MAX_VERTICES = mstc_pkg::MAX_VERTICES,
  parameter int MAX_EDGES    = mstc_pkg::MAX_EDGES,
  parameter int WEIGHT_BITS  = mstc_pkg::WEIGHT_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  mstc_pkg::mstc_cmd_t                 cmd,
  output mstc_pkg::mstc_sts_t                 sts,
  input  logic                                in_present,
  input  logic [mstc_pkg::END_BITS-1:0]       in_a,
  input  logic [mstc_pkg::END_BITS-1:0]       in_b,
  input  logic [mstc_pkg::INW_BITS-1:0]       in_w,
  input  logic                                cfg_we,
  input  logic [mstc_pkg::VCNT_BITS-1:0]      cfg_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_connected,
  output logic [mstc_pkg::COST_BITS-1:0]      out_cost,
  output logic [mstc_pkg::TAKEN_BITS-1:0]     out_taken,
  output logic                                out_overflow
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int FW = $clog2(MAX_EDGES + 1);
  localparam int EB = mstc_pkg::END_BITS;
  localparam int EW = 2 * EB + WEIGHT_BITS;
  localparam int SW = 33;

  // configuration and per-compute vertex count
  logic [mstc_pkg::VCNT_BITS-1:0] vertex_count;
  logic [VW:0]                    nact, nact_next;
  logic [VW:0]                    set_count;

  always_comb begin
    if (vertex_count == '0) nact_next = (VW+1)'(1);
    else if (32'(vertex_count) > MAX_VERTICES) nact_next = (VW+1)'(MAX_VERTICES);
    else nact_next = (VW+1)'(vertex_count);
  end

  // edge store
  logic [FW-1:0]          fill;
  logic                   dropped;
  logic [EW-1:0]          e_wdata, e_rdata;
  logic [AW-1:0]          e_raddr;
  logic                   e_we;

  assign e_we    = cmd.load && in_present && (32'(fill) < MAX_EDGES);
  assign e_wdata = {WEIGHT_BITS'(in_w), in_b, in_a};

  mstc_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_edges (
    .clk   (clk),
    .we    (e_we),
    .waddr (AW'(fill)),
    .wdata (e_wdata),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  // parent store
  logic [VW-1:0] ictr, v, ra;
  logic          p_we;
  logic [VW-1:0] p_waddr, p_wdata, p_rdata;

  assign p_we    = cmd.init_wr || cmd.link;
  assign p_waddr = cmd.init_wr ? ictr : ra;
  assign p_wdata = cmd.init_wr ? ictr : v;

  mstc_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_parent (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .raddr (v),
    .rdata (p_rdata)
  );

  // scan pass: find the smallest (weight, index) above the last visited key
  logic [FW-1:0]          scan_addr;
  logic                   rd_v;
  logic [FW-1:0]          rd_idx;
  logic                   found, have_last;
  logic [WEIGHT_BITS-1:0] best_w, last_w, c_w;
  logic [FW-1:0]          best_idx, last_idx;
  logic [EB-1:0]          best_a, best_b, c_a, c_b;
  logic                   above_last, below_best;

  assign e_raddr = AW'(scan_addr);
  assign c_a     = e_rdata[EB-1:0];
  assign c_b     = e_rdata[2*EB-1:EB];
  assign c_w     = e_rdata[EW-1:2*EB];

  assign above_last = !have_last || (c_w > last_w) ||
                      ((c_w == last_w) && (rd_idx > last_idx));
  assign below_best = !found || (c_w < best_w);

  // cost accumulate with saturation
  logic [mstc_pkg::COST_BITS-1:0]  cost;
  logic [mstc_pkg::TAKEN_BITS-1:0] taken;
  logic [SW-1:0]                   cost_sum;

  assign cost_sum = SW'(cost) + SW'(best_w);

  // status
  assign sts.init_last = (ictr == VW'(MAX_VERTICES - 1));
  assign sts.scan_done = (scan_addr == fill);
  assign sts.rd_pend   = rd_v;
  assign sts.found     = found;
  assign sts.out_range = (32'(best_a) >= 32'(nact)) || (32'(best_b) >= 32'(nact));
  assign sts.is_root   = (p_rdata == v);
  assign sts.same_set  = (ra == v);
  assign sts.more      = (set_count > (VW+1)'(1));
  assign sts.out_busy  = out_valid;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= mstc_pkg::VCNT_RESET;
      fill         <= '0;
      dropped      <= 1'b0;
      rd_v         <= 1'b0;
      found        <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) vertex_count <= cfg_value;
      if (cmd.load && in_present) begin
        if (e_we) fill <= fill + FW'(1);
        else dropped <= 1'b1;
      end
      rd_v <= cmd.scan_rd;
      if (cmd.scan_clr) found <= 1'b0;
      else if (rd_v && above_last && below_best) found <= 1'b1;
      if (cmd.publish) begin
        out_valid <= 1'b1;
        fill      <= '0;
        dropped   <= 1'b0;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      nact      <= nact_next;
      set_count <= nact_next;
      cost      <= '0;
      taken     <= '0;
      ictr      <= '0;
      have_last <= 1'b0;
    end
    if (cmd.init_wr) ictr <= ictr + VW'(1);
    if (cmd.scan_clr) scan_addr <= '0;
    else if (cmd.scan_rd) scan_addr <= scan_addr + FW'(1);
    rd_idx <= scan_addr;
    if (rd_v && above_last && below_best) begin
      best_w   <= c_w;
      best_idx <= rd_idx;
      best_a   <= c_a;
      best_b   <= c_b;
    end
    if (cmd.mark) begin
      have_last <= 1'b1;
      last_w    <= best_w;
      last_idx  <= best_idx;
    end
    if (cmd.sel_a) v <= VW'(best_a);
    else if (cmd.sel_b) v <= VW'(best_b);
    else if (cmd.hop) v <= p_rdata;
    if (cmd.save_a) ra <= v;
    if (cmd.link) begin
      set_count <= set_count - (VW+1)'(1);
      taken     <= taken + mstc_pkg::TAKEN_BITS'(1);
      cost      <= (cost_sum > SW'(mstc_pkg::COST_MAX)) ? mstc_pkg::COST_MAX
                                                        : cost_sum[mstc_pkg::COST_BITS-1:0];
    end
    if (cmd.publish) begin
      out_connected <= (set_count == (VW+1)'(1));
      out_cost      <= cost;
      out_taken     <= taken;
      out_overflow  <= dropped;
    end
  end

endmodule

[rtl/mstc_chk.sv]
// mstc_chk: port level checks for the tree cost unit, bound to the top level
// depends on minimum_spanning_tree_cost_unit
`timescale 1ns / 1ps

module mstc_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // the last item starts a compute, so input closes next cycle
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input open right after last item");

  // a new result only comes out of a compute
  a_res_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result without compute");

  // no edges taken means no cost
  a_zero_cost: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[32:25] == 8'd0) |-> (m_axis_tdata[24:1] == 24'd0))
    else $error("cost without taken edges");

endmodule

bind minimum_spanning_tree_cost_unit mstc_chk u_mstc_chk (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

[test/mstc_checker.sv]
// mstc_checker: watches the config, edge and result channels of the
// minimum spanning tree cost unit, predicts each result and compares it
// depends on mstc_pkg
`timescale 1ns / 1ps

module mstc_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  input  logic                                s_axis_tready,
  input  logic [mstc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  input  logic                                s_axis_tuser,
  input  logic                                s_axis_tlast,
  input  logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic [mstc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [mstc_pkg::VCNT_BITS-1:0]      cfg_data,
  output int                                  errors,
  output int                                  pending
);
  import mstc_pkg::*;

  // packed from the highest bit down, so connected sits in bit 0
  typedef struct packed {
    logic                  overflow;
    logic [TAKEN_BITS-1:0] edges_taken;
    logic [COST_BITS-1:0]  total_cost;
    logic                  connected;
  } tree_result_t;

  tree_result_t expected_trees[$];

  logic [VCNT_BITS-1:0]   vertex_count;
  logic [END_BITS-1:0]    edge_a [MAX_EDGES];
  logic [END_BITS-1:0]    edge_b [MAX_EDGES];
  logic [WEIGHT_BITS-1:0] edge_w [MAX_EDGES];
  int                     edge_count;
  logic                   edges_dropped;
  int                     parent [MAX_VERTICES];
  int                     visit_order [MAX_EDGES];

  assign pending = expected_trees.size();

  function automatic int set_root(int v);
    while (parent[v] != v) v = parent[v];
    return v;
  endfunction

  // kruskal over the stored edges, ties broken by arrival order
  task automatic predict_tree();
    tree_result_t r;
    int n, sets, taken, cost, key, j, ra, rb;
    n = (vertex_count == 0) ? 1 : (vertex_count > MAX_VERTICES) ? MAX_VERTICES : vertex_count;
    for (int v = 0; v < MAX_VERTICES; v++) parent[v] = v;
    for (int i = 0; i < edge_count; i++) begin
      key = i;
      j = i;
      while (j > 0 && edge_w[visit_order[j-1]] > edge_w[key]) begin
        visit_order[j] = visit_order[j-1];
        j--;
      end
      visit_order[j] = key;
    end
    sets = n;
    taken = 0;
    cost = 0;
    for (int k = 0; k < edge_count && sets > 1; k++) begin
      if (edge_a[visit_order[k]] < n && edge_b[visit_order[k]] < n) begin
        ra = set_root(edge_a[visit_order[k]]);
        rb = set_root(edge_b[visit_order[k]]);
        if (ra != rb) begin
          parent[ra] = rb;
          sets--;
          taken++;
          cost = cost + edge_w[visit_order[k]];
          if (cost > COST_MAX) cost = COST_MAX;
        end
      end
    end
    r.connected   = (sets == 1);
    r.total_cost  = cost[COST_BITS-1:0];
    r.edges_taken = taken[TAKEN_BITS-1:0];
    r.overflow    = edges_dropped;
    expected_trees.insert(expected_trees.size(), r);
  endtask

  // track register writes and incoming edges
  always @(posedge clk) begin
    if (rst) begin
      vertex_count <= VCNT_RESET;
      edge_count = 0;
      edges_dropped = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) vertex_count <= cfg_data;
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser) begin
          if (edge_count < MAX_EDGES) begin
            edge_a[edge_count] = s_axis_tdata[7:0];
            edge_b[edge_count] = s_axis_tdata[15:8];
            edge_w[edge_count] = s_axis_tdata[31:16];
            edge_count++;
          end else begin
            edges_dropped = 1'b1;
          end
        end
        if (s_axis_tlast) begin
          predict_tree();
          edge_count = 0;
          edges_dropped = 1'b0;
        end
      end
    end
  end

  // compare each result item with the oldest expectation
  always @(posedge clk) begin
    tree_result_t got, want;
    if (rst) begin
      errors = 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[33:0];
      if (expected_trees.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
      end else begin
        want = expected_trees.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: conn %b/%b cost %0d/%0d taken %0d/%0d ovf %b/%b (exp/got)",
                     want.connected, got.connected, want.total_cost, got.total_cost,
                     want.edges_taken, got.edges_taken, want.overflow, got.overflow);
        end
      end
    end
  end

endmodule

[test/testbench.sv]
// testbench: stimulus and verdict for minimum_spanning_tree_cost_unit
// depends on mstc_pkg, the unit's rtl and mstc_checker
`timescale 1ns / 1ps

module testbench;
  import mstc_pkg::*;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;  // end_a, end_b, edge_weight
  logic                   s_axis_tuser = 1'b0;  // edge_present
  logic                   s_axis_tlast = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;  // connected, total_cost, edges_taken, overflow
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [VCNT_BITS-1:0]   cfg_data = '0;
  int                     errors, pending;
  int                     burst_left = 0;
  int                     gap_max = 4;
  int                     active_n = 1;
  logic [15:0]            stall_pattern = 16'hFFFF;
  int                     stall_age = 0;

  always #5 clk = ~clk;

  minimum_spanning_tree_cost_unit uut (.*);

  mstc_checker check (.*);

  // receiver stalls on a rotating pattern, redrawn now and then
  always @(posedge clk) begin
    stall_age <= stall_age + 1;
    if (stall_age % 700 == 0)
      stall_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
    else
      stall_pattern <= {stall_pattern[14:0], stall_pattern[15]};
    m_axis_tready <= stall_pattern[0] | (stall_age % 97 == 0);
  end

  // one edge item, sent in bursts with random gaps
  task automatic put_item(logic present, logic [7:0] a, logic [7:0] b,
                          logic [15:0] w, logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {w, b, a};
    s_axis_tuser  <= present;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // register write, only once the unit has drained
  task automatic set_vertices(logic [8:0] v);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    active_n = (v == 0) ? 1 : (v > MAX_VERTICES) ? MAX_VERTICES : v;
    gap_max = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
  endtask

  // random graph: mostly in-range edges, some noise and out-of-range ends
  task automatic random_graph(int edges);
    int sel;
    logic [15:0] w;
    for (int i = 0; i < edges; i++) begin
      sel = $urandom_range(0, 19);
      w = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 7)) : 16'($urandom);
      if (sel == 0)
        put_item(1'b0, 8'($urandom), 8'($urandom), 16'($urandom), 1'b0);
      else if (sel < 3)
        put_item(1'b1, 8'($urandom), 8'($urandom), w, 1'b0);
      else
        put_item(1'b1, 8'($urandom_range(0, active_n - 1)),
                 8'($urandom_range(0, active_n - 1)), w, 1'b0);
    end
    if ($urandom_range(0, 1))
      put_item(1'b0, 8'($urandom), 8'($urandom), 16'($urandom), 1'b1);
    else
      put_item(1'b1, 8'($urandom_range(0, active_n - 1)),
               8'($urandom_range(0, active_n - 1)), 16'($urandom), 1'b1);
  endtask

  initial begin
    int sent;
    logic [8:0] v;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty graph at reset count, extremes, self loop, count clamps
    put_item(1'b0, 8'd0, 8'd0, 16'd0, 1'b1);
    set_vertices(9'd256);
    put_item(1'b1, 8'd0, 8'd255, 16'hFFFF, 1'b0);
    put_item(1'b1, 8'd255, 8'd0, 16'd0, 1'b0);
    put_item(1'b1, 8'd7, 8'd7, 16'd5, 1'b0);
    put_item(1'b0, 8'hFF, 8'hFF, 16'hFFFF, 1'b0);
    put_item(1'b1, 8'd1, 8'd0, 16'd3, 1'b1);
    set_vertices(9'd0);
    put_item(1'b1, 8'd0, 8'd1, 16'd9, 1'b0);
    put_item(1'b1, 8'd0, 8'd0, 16'd9, 1'b1);
    set_vertices(9'd511);
    put_item(1'b1, 8'd255, 8'd254, 16'd1, 1'b1);
    set_vertices(9'd3);
    put_item(1'b1, 8'd0, 8'd1, 16'd4, 1'b0);
    put_item(1'b1, 8'd1, 8'd0, 16'd4, 1'b0);
    put_item(1'b1, 8'd2, 8'd3, 16'd1, 1'b0);
    put_item(1'b1, 8'd1, 8'd2, 16'd4, 1'b1);

    // store overflow: two vertices, more edges than the store holds
    set_vertices(9'd2);
    for (int i = 0; i < MAX_EDGES + 6; i++)
      put_item(1'b1, 8'($urandom_range(0, 1)), 8'($urandom_range(0, 1)),
               16'($urandom), i == MAX_EDGES + 5);
    random_graph(4);

    // full chain at the widest count, every weight at its maximum
    set_vertices(9'd256);
    for (int i = 0; i < 255; i++)
      put_item(1'b1, 8'(i), 8'(i + 1), 16'hFFFF, i == 254);
    sent = MAX_EDGES + 300;

    // random phases, each with its own vertex count
    while (sent < 1950) begin
      case ($urandom_range(0, 7))
        0: v = 9'd1;
        1: v = 9'd256;
        2: v = 9'($urandom_range(257, 511));
        3: v = 9'($urandom_range(0, 511));
        default: v = 9'($urandom_range(2, 24));
      endcase
      set_vertices(v);
      for (int g = 0; g < 4; g++) begin
        int len;
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 120)
                                           : $urandom_range(0, 24);
        random_graph(len);
        sent += len + 1;
      end
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end

  initial begin
    #80ms;
    $display("testbench failed");
    $finish;
  end

endmodule

[filelist.f]
rtl/mstc_pkg.sv
rtl/mstc_ram.sv
rtl/mstc_ctrl.sv
rtl/mstc_dp.sv
rtl/minimum_spanning_tree_cost_unit.sv
rtl/mstc_chk.sv
test/mstc_checker.sv
test/testbench.sv
